// ----- src/cge_pkg.sv -----
// ----------------------------------------------------------------------------
// cge_pkg: shared types and constants of the color gradient evaluator
// Holds the channel payloads, the scan token that travels along the key
// cells, the key write bus and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package cge_pkg;

  // Default table depth.
  localparam int KEY_DEPTH_DEF = 8;

  // Item kinds.
  localparam logic KIND_EVAL = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Fraction value for a full step to the later key (Q1.16 one).
  localparam logic [16:0] FRAC_ONE  = 17'h10000;
  localparam logic [16:0] FRAC_ZERO = 17'h00000;

  typedef struct packed {
    logic        kind;
    logic [2:0]  key_slot;
    logic [15:0] key_time;
    logic [15:0] key_red;
    logic [15:0] key_green;
    logic [15:0] key_blue;
    logic [15:0] key_alpha;
    logic [15:0] query_time;
  } item_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic [15:0] range_start;
    logic [15:0] range_end;
  } result_t;

  typedef struct packed {
    logic [3:0] key_count;
  } cfg_t;

  // How the fraction of the found segment is formed.
  typedef enum logic [1:0] {
    FMODE_ZERO,
    FMODE_FULL,
    FMODE_DIV
  } fmode_t;

  // Key write broadcast to all cells.
  typedef struct packed {
    logic        en;
    logic [2:0]  slot;
    logic [15:0] ktime;
    logic [63:0] color;
  } key_wr_t;

  // Token handed from cell to cell. The first pass gathers the range and
  // the last key color, the second pass searches the segment.
  typedef struct packed {
    logic        valid;
    logic        pass;
    logic        found;
    fmode_t      fmode;
    logic [15:0] q;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] pt;
    logic [63:0] pc;
    logic [63:0] c0;
    logic [63:0] c1;
    logic [15:0] num;
    logic [15:0] den;
  } tok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_B,
    S_DIV,
    S_BLEND,
    S_PUSH
  } state_t;

endpackage
`default_nettype wire

// ----- src/cge_stream_if.sv -----
// ----------------------------------------------------------------------------
// cge_stream_if: valid/ready channel
// Carries one payload per transaction from a source to a sink.
// ----------------------------------------------------------------------------
`default_nettype none
interface cge_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/cge_cell.sv -----
// ----------------------------------------------------------------------------
// cge_cell: one key slot of the gradient table
// Stores one key time and color and updates the passing token each cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cge_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cge_pkg::key_wr_t    wr,
  input  wire logic [CNT_W-1:0]    n,
  input  wire cge_pkg::tok_t       tin,
  output cge_pkg::tok_t            tout
);
  import cge_pkg::*;

  logic [15:0] ktime;
  logic [63:0] color;
  tok_t        tok_next;
  logic        in_use;

  // Key storage, written by a matching load.
  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.slot) == IDX)) begin
      ktime <= wr.ktime;
      color <= wr.color;
    end
  end

  assign in_use = (IDX < int'(n));

  // Token update. A query that lands exactly on the later key takes the full
  // step, since that fraction does not fit the divider's 16-bit quotient.
  always_comb begin
    tok_next = tin;
    if (!tin.pass) begin
      if (IDX == 0) begin
        tok_next.lo = ktime;
      end
      if (IDX == int'(n) - 1) begin
        tok_next.hi = ktime;
        tok_next.c0 = color;
      end
    end else if ((IDX >= 1) && in_use && !tin.found && (tin.q <= ktime)) begin
      tok_next.found = 1'b1;
      tok_next.c0    = tin.pc;
      tok_next.c1    = color;
      tok_next.num   = tin.q - tin.pt;
      tok_next.den   = ktime - tin.pt;
      if (ktime <= tin.pt) begin
        tok_next.fmode = FMODE_FULL;
      end else if (tin.q <= tin.pt) begin
        tok_next.fmode = FMODE_ZERO;
      end else if (tin.q == ktime) begin
        tok_next.fmode = FMODE_FULL;
      end else begin
        tok_next.fmode = FMODE_DIV;
      end
    end
    tok_next.pt = ktime;
    tok_next.pc = color;
  end

  // Hand the token to the neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout.valid <= tin.valid;
    end
    tout.pass  <= tok_next.pass;
    tout.found <= tok_next.found;
    tout.fmode <= tok_next.fmode;
    tout.q     <= tok_next.q;
    tout.lo    <= tok_next.lo;
    tout.hi    <= tok_next.hi;
    tout.pt    <= tok_next.pt;
    tout.pc    <= tok_next.pc;
    tout.c0    <= tok_next.c0;
    tout.c1    <= tok_next.c1;
    tout.num   <= tok_next.num;
    tout.den   <= tok_next.den;
  end

endmodule
`default_nettype wire

// ----- src/cge_divider.sv -----
// ----------------------------------------------------------------------------
// cge_divider: restoring divider for the segment fraction
// Computes floor((num << 16) / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cge_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] num,
  input  wire logic [15:0] den,
  output logic [15:0]      quo,
  output logic             done
);
  logic        busy;
  logic [3:0]  cnt;
  logic [16:0] rem;
  logic [15:0] dsr;
  logic [16:0] shifted;
  logic        ge;

  assign shifted = {rem[15:0], 1'b0};
  assign ge      = (shifted >= {1'b0, dsr});

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one subtract and compare a cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      dsr <= den;
    end else if (busy) begin
      rem <= ge ? (shifted - {1'b0, dsr}) : shifted;
      quo <= {quo[14:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- src/cge_blend.sv -----
// ----------------------------------------------------------------------------
// cge_blend: channel blender
// Blends two RGBA colors by a Q1.16 fraction, one channel a cycle through a
// single multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module cge_blend (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] c0,
  input  wire logic [63:0] c1,
  input  wire logic [16:0] frac,
  output logic [63:0]      color,
  output logic             done
);
  logic               busy;
  logic [1:0]         ch;
  logic [63:0]        ca;
  logic [63:0]        cb;
  logic [16:0]        f;
  logic [15:0]        a;
  logic [15:0]        b;
  logic signed [16:0] d;
  logic signed [34:0] prod;
  logic signed [34:0] sum;

  // a * (1 - f) + b * f + half = a * 2^16 + (b - a) * f + half.
  assign a    = ca[16*ch +: 16];
  assign b    = cb[16*ch +: 16];
  assign d    = $signed({1'b0, b}) - $signed({1'b0, a});
  assign prod = 35'(d * $signed({1'b0, f}));
  assign sum  = $signed({3'b000, a, 16'h0000}) + prod + 35'sd32768;

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ch   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ch   <= '0;
      end else if (busy) begin
        ch <= ch + 2'd1;
        if (ch == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and per-channel results.
  always_ff @(posedge clk) begin
    if (start) begin
      ca <= c0;
      cb <= c1;
      f  <= frac;
    end else if (busy) begin
      color[16*ch +: 16] <= sum[31:16];
    end
  end

endmodule
`default_nettype wire

// ----- src/color_gradient_evaluator.sv -----
// ----------------------------------------------------------------------------
// color_gradient_evaluator: piecewise linear RGBA gradient
// Loads keys into a row of cells and evaluates query times against them.
//
//  channel   dir  payload            transaction
//  items     in   cge_pkg::item_t    load a key or evaluate a query
//  results   out  cge_pkg::result_t  one result color per evaluate
//  cfg       in   cge_pkg::cfg_t     key count in use
//
// A load writes its key slot when it is accepted. An evaluate sends the token
// across the cell row twice (range pass, then search pass); the divider then
// forms the fraction of a divided segment and the blender mixes the channels.
// Reset clears the key count and all control; key slots hold no value until
// loaded. A stalled result waits in the output register while loads go on.
// ----------------------------------------------------------------------------
`default_nettype none
module color_gradient_evaluator #(
  parameter int KEY_DEPTH = cge_pkg::KEY_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  cge_stream_if.sink   items,
  cge_stream_if.source results,
  cge_stream_if.sink   cfg
);
  import cge_pkg::*;

  localparam int CNT_W = $clog2(KEY_DEPTH + 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] n;
  item_t            item;
  key_wr_t          wr;
  tok_t             tok [KEY_DEPTH+1];
  tok_t             tok_first;
  tok_t             tok_end;
  logic [15:0]      q_raw;
  logic [15:0]      q_clamp;
  logic [15:0]      lo;
  logic [15:0]      hi;
  logic [63:0]      c0;
  logic [63:0]      c1;
  logic [63:0]      color;
  logic             div_start;
  logic             div_done;
  logic [15:0]      quo;
  logic             bl_start;
  logic             bl_done;
  logic [63:0]      bl_c0;
  logic [63:0]      bl_c1;
  logic [16:0]      bl_f;
  logic [63:0]      bl_color;
  logic             accept;
  logic             push;
  logic             res_valid;
  result_t          res;

  assign item    = items.payload;
  assign accept  = items.valid && items.ready;
  assign tok_end = tok[KEY_DEPTH];
  assign push    = (state == S_PUSH) && (!res_valid || results.ready);

  assign items.ready     = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign results.valid   = res_valid;
  assign results.payload = res;

  // Key count register, saturating at the table depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cfg.valid) begin
      n <= (int'(cfg.payload.key_count) > KEY_DEPTH) ? CNT_W'(KEY_DEPTH)
                                                     : CNT_W'(cfg.payload.key_count);
    end
  end

  // Key write broadcast.
  always_comb begin
    wr.en    = accept && (item.kind == KIND_LOAD);
    wr.slot  = item.key_slot;
    wr.ktime = item.key_time;
    wr.color = {item.key_alpha, item.key_blue, item.key_green, item.key_red};
  end

  // Query clamped to the range found by the first pass.
  always_comb begin
    q_clamp = q_raw;
    if (q_raw < tok_end.lo) begin
      q_clamp = tok_end.lo;
    end else if (q_raw > tok_end.hi) begin
      q_clamp = tok_end.hi;
    end
  end

  // Token launched into the first cell.
  always_comb begin
    tok_first       = '0;
    tok_first.fmode = FMODE_ZERO;
    if (state == S_IDLE) begin
      tok_first.valid = accept && (item.kind == KIND_EVAL) && (n != '0);
    end else if (state == S_SCAN_A) begin
      tok_first.valid = tok_end.valid;
      tok_first.pass  = 1'b1;
      tok_first.q     = q_clamp;
      tok_first.c0    = tok_end.c0;
      tok_first.c1    = tok_end.c0;
    end
  end

  assign tok[0] = tok_first;

  // Row of key cells.
  for (genvar i = 0; i < KEY_DEPTH; i++) begin : g_cell
    cge_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk (clk),
      .rst (rst),
      .wr  (wr),
      .n   (n),
      .tin (tok[i]),
      .tout(tok[i+1])
    );
  end

  cge_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (tok_end.num),
    .den  (tok_end.den),
    .quo  (quo),
    .done (div_done)
  );

  // Blend operands come straight from the token unless a division ran.
  always_comb begin
    bl_c0 = c0;
    bl_c1 = c1;
    bl_f  = {1'b0, quo};
    if (state == S_SCAN_B) begin
      bl_c0 = tok_end.c0;
      bl_c1 = tok_end.c1;
      bl_f  = (tok_end.fmode == FMODE_FULL) ? FRAC_ONE : FRAC_ZERO;
    end
  end

  cge_blend u_blend (
    .clk  (clk),
    .rst  (rst),
    .start(bl_start),
    .c0   (bl_c0),
    .c1   (bl_c1),
    .frac (bl_f),
    .color(bl_color),
    .done (bl_done)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit starts.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    bl_start   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && (item.kind == KIND_EVAL)) begin
          state_next = (n == '0) ? S_PUSH : S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        if (tok_end.valid) begin
          state_next = S_SCAN_B;
        end
      end
      S_SCAN_B: begin
        if (tok_end.valid) begin
          if (tok_end.fmode == FMODE_DIV) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end else begin
            bl_start   = 1'b1;
            state_next = S_BLEND;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          bl_start   = 1'b1;
          state_next = S_BLEND;
        end
      end
      S_BLEND: begin
        if (bl_done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Working registers of one evaluate transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_raw <= item.query_time;
      lo    <= '0;
      hi    <= '0;
      color <= '0;
    end
    if ((state == S_SCAN_A) && tok_end.valid) begin
      lo <= tok_end.lo;
      hi <= tok_end.hi;
    end
    if ((state == S_SCAN_B) && tok_end.valid) begin
      c0 <= tok_end.c0;
      c1 <= tok_end.c1;
    end
    if ((state == S_BLEND) && bl_done) begin
      color <= bl_color;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res.out_red     <= color[15:0];
      res.out_green   <= color[31:16];
      res.out_blue    <= color[47:32];
      res.out_alpha   <= color[63:48];
      res.range_start <= lo;
      res.range_end   <= hi;
    end
  end

  // A token leaves the cell row only while the controller scans.
  a_tok_scan: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid |-> (state == S_SCAN_A || state == S_SCAN_B))
    else $error("token left the cell row outside a scan");

  // The divider finishes only while the controller waits on it.
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its state");

  // The blender finishes only while the controller waits on it.
  a_blend_state: assert property (@(posedge clk) disable iff (rst)
    bl_done |-> (state == S_BLEND))
    else $error("blender finished outside its state");

  // A new result appears only after the push state.
  a_res_push: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_PUSH))
    else $error("result raised without a push");

endmodule
`default_nettype wire
